### rtl/bst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bst_pkg: types, constants and scan functions of the byte stream tokenizer
// Holds the scan state, the bundle of up to three result items that one
// input item causes, the keyword table and the per-byte scan step.
// ---------------------------------------------------------------------------
package bst_pkg;

   localparam int unsigned MaxResults = 3;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_STR     = 4'd1,
      MODE_NUM     = 4'd2,
      MODE_IDENT   = 4'd3,
      MODE_COMMENT = 4'd4,
      MODE_GT      = 4'd5,
      MODE_LT      = 4'd6,
      MODE_EQ      = 4'd7,
      MODE_BANG    = 4'd8,
      MODE_SLASH   = 4'd9
   } scan_mode_type;

   typedef enum logic [4:0] {
      KIND_EOF       = 5'd0,
      KIND_STRING    = 5'd1,
      KIND_NUMBER    = 5'd2,
      KIND_FLOAT     = 5'd3,
      KIND_GT        = 5'd4,
      KIND_GE        = 5'd5,
      KIND_LT        = 5'd6,
      KIND_LE        = 5'd7,
      KIND_ASSIGN    = 5'd8,
      KIND_EQ        = 5'd9,
      KIND_NE        = 5'd10,
      KIND_SHOW      = 5'd11,
      KIND_WONDERING = 5'd12,
      KIND_OMAE      = 5'd13,
      KIND_WA        = 5'd14,
      KIND_BOOL      = 5'd15,
      KIND_IDENT     = 5'd16,
      KIND_PLUS      = 5'd17,
      KIND_MINUS     = 5'd18,
      KIND_MUL       = 5'd19,
      KIND_DIV       = 5'd20,
      KIND_LPAREN    = 5'd21,
      KIND_RPAREN    = 5'd22,
      KIND_LBRACE    = 5'd23,
      KIND_RBRACE    = 5'd24
   } token_kind_type;

   // Keywords, left aligned in 72 bits, index 0 in the lowest slot
   localparam logic [5:0][71:0] KW_TEXT = {
      {"false", 32'h0},
      {"true", 40'h0},
      {"wa", 56'h0},
      {"omae", 40'h0},
      {"wondering"},
      {"show", 40'h0}
   };
   localparam logic [5:0][3:0] KW_LEN = {4'd5, 4'd4, 4'd2, 4'd4, 4'd9, 4'd4};
   localparam logic [5:0][4:0] KW_KIND = {
      KIND_BOOL, KIND_BOOL, KIND_WA, KIND_OMAE, KIND_WONDERING, KIND_SHOW
   };

   typedef struct packed {
      scan_mode_type mode;
      logic          seen_dot;
      logic [5:0]    cand;
      logic [3:0]    len;
   } scan_state_type;

   localparam scan_state_type IdleState = '{
      mode: MODE_IDLE, seen_dot: 1'b0, cand: 6'h3f, len: 4'd0
   };

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] text_byte;
      logic       token_done;
      logic [4:0] token_kind;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MaxResults-1:0] item;
      logic [1:0]                    count;
   } rsp_bundle_type;

   typedef struct packed {
      scan_state_type st;
      rsp_bundle_type b;
   } scan_ctx_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   // Pick one character of a left aligned keyword
   function automatic logic [7:0] kw_char(input logic [71:0] text, input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      for (int j = 0; j < 9; j++) begin
         if (pos == 4'(j)) ch = text[71-8*j -: 8];
      end
      return ch;
   endfunction

   // Append one result item; drop beyond the bundle size
   function automatic scan_ctx_type put(input scan_ctx_type ctx, input logic bv,
                                        input logic [7:0] data, input logic done,
                                        input logic [4:0] kind);
      scan_ctx_type r;
      r = ctx;
      if (ctx.b.count != 2'd3) begin
         r.b.item[ctx.b.count].byte_valid = bv;
         r.b.item[ctx.b.count].text_byte  = bv ? data : 8'h00;
         r.b.item[ctx.b.count].token_done = done;
         r.b.item[ctx.b.count].token_kind = done ? kind : 5'd0;
         r.b.count = ctx.b.count + 2'd1;
      end
      return r;
   endfunction

   // Advance the keyword candidate flags by one identifier byte
   function automatic scan_state_type feed_ident(input scan_state_type st,
                                                 input logic [7:0] c);
      scan_state_type r;
      r = st;
      for (int k = 0; k < 6; k++) begin
         r.cand[k] = st.cand[k] && (st.len < KW_LEN[k]) && (kw_char(KW_TEXT[k], st.len) == c);
      end
      if (st.len != 4'd15) r.len = st.len + 4'd1;
      return r;
   endfunction

   // First keyword still matching at full length, else identifier
   function automatic logic [4:0] ident_kind(input scan_state_type st);
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = 5; k >= 0; k--) begin
         if (st.cand[k] && st.len == KW_LEN[k]) kind = KW_KIND[k];
      end
      return kind;
   endfunction

   // Close the open token, then return to idle
   function automatic scan_ctx_type close_open(input scan_ctx_type ctx);
      scan_ctx_type r;
      logic         has_kind;
      logic [4:0]   kind;
      logic [1:0]   last;
      r        = ctx;
      has_kind = 1'b0;
      kind     = KIND_EOF;
      unique case (ctx.st.mode)
         MODE_STR: begin
            has_kind = 1'b1;
            kind     = KIND_STRING;
         end
         MODE_NUM: begin
            has_kind = 1'b1;
            kind     = ctx.st.seen_dot ? KIND_FLOAT : KIND_NUMBER;
         end
         MODE_IDENT: begin
            has_kind = 1'b1;
            kind     = ident_kind(ctx.st);
         end
         MODE_GT:    r = put(r, 1'b1, ">", 1'b1, KIND_GT);
         MODE_LT:    r = put(r, 1'b1, "<", 1'b1, KIND_LT);
         MODE_EQ:    r = put(r, 1'b1, "=", 1'b1, KIND_ASSIGN);
         MODE_SLASH: r = put(r, 1'b1, "/", 1'b1, KIND_DIV);
         default: ;
      endcase
      if (has_kind) begin
         last = r.b.count - 2'd1;
         // Ride the marker on an open text byte, else send it alone
         if (r.b.count != 2'd0 && r.b.item[last].byte_valid && !r.b.item[last].token_done)
         begin
            r.b.item[last].token_done = 1'b1;
            r.b.item[last].token_kind = kind;
         end else begin
            r = put(r, 1'b0, 8'h00, 1'b1, kind);
         end
      end
      r.st = IdleState;
      return r;
   endfunction

   // Scan a byte from idle
   function automatic scan_ctx_type start_token(input scan_ctx_type ctx, input logic [7:0] c);
      scan_ctx_type r;
      r    = ctx;
      r.st = IdleState;
      if (is_space(c)) begin
         r.st.mode = MODE_IDLE;
      end else if (c == "\"") begin
         r.st.mode = MODE_STR;
      end else if (is_digit(c)) begin
         r.st.mode = MODE_NUM;
         r = put(r, 1'b1, c, 1'b0, KIND_EOF);
      end else if (is_alpha(c) || c == "_") begin
         r.st      = feed_ident(r.st, c);
         r.st.mode = MODE_IDENT;
         r = put(r, 1'b1, c, 1'b0, KIND_EOF);
      end else begin
         unique case (c)
            ">": r.st.mode = MODE_GT;
            "<": r.st.mode = MODE_LT;
            "=": r.st.mode = MODE_EQ;
            "!": r.st.mode = MODE_BANG;
            "/": r.st.mode = MODE_SLASH;
            "+": r = put(r, 1'b1, c, 1'b1, KIND_PLUS);
            "-": r = put(r, 1'b1, c, 1'b1, KIND_MINUS);
            "*": r = put(r, 1'b1, c, 1'b1, KIND_MUL);
            "(": r = put(r, 1'b1, c, 1'b1, KIND_LPAREN);
            ")": r = put(r, 1'b1, c, 1'b1, KIND_RPAREN);
            "{": r = put(r, 1'b1, c, 1'b1, KIND_LBRACE);
            "}": r = put(r, 1'b1, c, 1'b1, KIND_RBRACE);
            default: ;
         endcase
      end
      return r;
   endfunction

   // Scan one valid nonzero byte in the current mode
   function automatic scan_ctx_type scan_byte(input scan_ctx_type ctx, input logic [7:0] c);
      scan_ctx_type r;
      logic [7:0]   first;
      logic [4:0]   kind;
      r = ctx;
      unique case (ctx.st.mode)
         MODE_STR: begin
            if (c == "\"") r = close_open(r);
            else r = put(r, 1'b1, c, 1'b0, KIND_EOF);
         end
         MODE_NUM: begin
            if (is_digit(c)) begin
               r = put(r, 1'b1, c, 1'b0, KIND_EOF);
            end else if (c == "." && !ctx.st.seen_dot) begin
               r.st.seen_dot = 1'b1;
               r = put(r, 1'b1, c, 1'b0, KIND_EOF);
            end else if (c == ".") begin
               r = close_open(r);
            end else begin
               r = start_token(close_open(r), c);
            end
         end
         MODE_IDENT: begin
            if (is_word(c)) begin
               r.st = feed_ident(r.st, c);
               r = put(r, 1'b1, c, 1'b0, KIND_EOF);
            end else begin
               r = start_token(close_open(r), c);
            end
         end
         MODE_COMMENT: begin
            if (c == 8'h0a) r.st = IdleState;
         end
         MODE_GT, MODE_LT, MODE_EQ: begin
            if (c == "=") begin
               first = (ctx.st.mode == MODE_GT) ? 8'(">") :
                       ((ctx.st.mode == MODE_LT) ? 8'("<") : 8'("="));
               kind  = (ctx.st.mode == MODE_GT) ? KIND_GE :
                       ((ctx.st.mode == MODE_LT) ? KIND_LE : KIND_EQ);
               r = put(r, 1'b1, first, 1'b0, KIND_EOF);
               r = put(r, 1'b1, "=", 1'b1, kind);
               r.st = IdleState;
            end else begin
               r = start_token(close_open(r), c);
            end
         end
         MODE_BANG: begin
            if (c == "=") begin
               r = put(r, 1'b1, "!", 1'b0, KIND_EOF);
               r = put(r, 1'b1, "=", 1'b1, KIND_NE);
               r.st = IdleState;
            end else begin
               r = start_token(r, c);
            end
         end
         MODE_SLASH: begin
            if (c == "/") r.st.mode = MODE_COMMENT;
            else r = start_token(close_open(r), c);
         end
         default: r = start_token(r, c);
      endcase
      return r;
   endfunction

endpackage

### rtl/byte_stream_tokenizer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_stream_tokenizer_core: streaming lexical scanner
// Takes one source byte per item and streams token text bytes and done
// markers that carry the token kind.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per item (tdata), with has_char in tuser
//   and the end-of-text flag in tlast. rsp_* carries result items: byte
//   valid, text byte and done flag in tdata, the token kind in tuser, and
//   tlast on the final result caused by one input item.
//   An accepted item is scanned in the cycle of acceptance; its results
//   (zero to three) sit in a result bundle register and leave one per cycle
//   while the receiver is ready, the first in the cycle after acceptance.
//   The single result channel drains the bundle. The next item is accepted
//   in the cycle the last result of the bundle is taken, so there is no bubble.
//   Items causing no result go through at one per cycle while no bundle is pending.
//   Reset returns the scanner to idle and empties the bundle.
//   When the receiver stalls, the current result holds and req_tready stays
//   low while a bundle is pending.
// ---------------------------------------------------------------------------
module byte_stream_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] byte_valid, [8:1] text_byte, [9] token_done
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   bst_pkg::scan_state_type state_ff;
   bst_pkg::rsp_bundle_type bundle_ff;
   bst_pkg::rsp_bundle_type bundle_in;
   logic                    pend_valid_ff;
   logic [1:0]              idx_ff;
   bst_pkg::scan_ctx_type   ctx;
   bst_pkg::rsp_item_type   cur_item;
   logic                    end_flag;
   logic                    req_accept;
   logic                    rsp_take;
   logic                    last_idx;

   // Scan the incoming item against the current state
   always_comb begin
      ctx.st   = state_ff;
      ctx.b    = '0;
      end_flag = req_tlast || (req_tuser && req_tdata == 8'h00);
      if (req_tuser && req_tdata != 8'h00) ctx = bst_pkg::scan_byte(ctx, req_tdata);
      if (end_flag) begin
         ctx    = bst_pkg::close_open(ctx);
         ctx    = bst_pkg::put(ctx, 1'b0, 8'h00, 1'b1, bst_pkg::KIND_EOF);
         ctx.st = bst_pkg::IdleState;
      end
      bundle_in = ctx.b;
   end

   // Handshakes
   assign last_idx   = (idx_ff == bundle_ff.count - 2'd1);
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_tready = !pend_valid_ff || (rsp_tready && last_idx);
   assign req_accept = req_tvalid && req_tready;

   // Advance scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bst_pkg::IdleState;
      end else if (req_accept) begin
         state_ff <= ctx.st;
      end
   end

   // Load the result bundle and step through it
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         if (rsp_take) begin
            if (last_idx) pend_valid_ff <= 1'b0;
            else idx_ff <= idx_ff + 2'd1;
         end
         if (req_accept && bundle_in.count != 2'd0) begin
            pend_valid_ff <= 1'b1;
            idx_ff        <= 2'd0;
         end
      end
   end

   // Hold bundle payload
   always_ff @(posedge clock) begin
      if (req_accept && bundle_in.count != 2'd0) bundle_ff <= bundle_in;
   end

   // Drive the result channel
   always_comb begin
      cur_item = (idx_ff == 2'd3) ? '0 : bundle_ff.item[idx_ff];
   end

   assign rsp_tvalid = pend_valid_ff;
   assign rsp_tdata  = {6'd0, cur_item.token_done, cur_item.text_byte, cur_item.byte_valid};
   assign rsp_tuser  = cur_item.token_kind;
   assign rsp_tlast  = last_idx;

`ifndef SYNTHESIS
   // A pending bundle is never empty and the index stays inside it
   a_bundle_index: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (bundle_ff.count != 2'd0 && idx_ff < bundle_ff.count))
      else $error("result index outside pending bundle");

   // A new item is taken only when the bundle is empty or draining its last result
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || (rsp_tlast && rsp_tready)))
      else $error("item accepted while results still pending");

   // Taking the last result with no new item leaves the channel idle
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_tlast && !req_accept) |=> !rsp_tvalid)
      else $error("result channel busy after bundle drained");
`endif

endmodule

### sim/tb_byte_stream_tokenizer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_byte_stream_tokenizer_core: self-checking bench for the token scanner
// Feeds directed and random source text, byte by byte, into the scanner
// under random stalls on both sides. A predictor tracks the scan state and
// computes the token text bytes and done markers that each accepted byte
// should cause. Every result leaving the block is checked against them.
// ---------------------------------------------------------------------------
module tb_byte_stream_tokenizer_core;

   // One expected or observed token result
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] text_byte;
      logic       token_done;
      logic [4:0] token_kind;
      logic       last;
   } tok_result_type;

   // One source item
   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       end_of_text;
   } src_item_type;

   // Tracks the scan state and the token results still owed by the block
   class token_tracker_type;
      bst_pkg::scan_mode_type mode;
      logic                   dot;
      logic [5:0]             cand;
      logic [3:0]             len;
      tok_result_type         batch[$];
      tok_result_type         expected_results[$];
      string                  kw_word[6];
      logic [4:0]             kw_kind[6];
      int                     errors;

      function new();
         kw_word = '{"show", "wondering", "omae", "wa", "true", "false"};
         kw_kind = '{bst_pkg::KIND_SHOW, bst_pkg::KIND_WONDERING, bst_pkg::KIND_OMAE,
                     bst_pkg::KIND_WA, bst_pkg::KIND_BOOL, bst_pkg::KIND_BOOL};
         errors  = 0;
         go_idle();
      endfunction

      function bit digit_char(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit letter_char(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit blank_char(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function void go_idle();
         mode = bst_pkg::MODE_IDLE;
         dot  = 1'b0;
         cand = 6'h3f;
         len  = 4'd0;
      endfunction

      // Append one result for the current item, at most three per item
      function void emit(logic bv, logic [7:0] ch, logic dn, logic [4:0] kd);
         tok_result_type r;
         if (batch.size() >= bst_pkg::MaxResults) return;
         r.byte_valid = bv;
         r.text_byte  = bv ? ch : 8'h00;
         r.token_done = dn;
         r.token_kind = dn ? kd : 5'd0;
         r.last       = 1'b0;
         batch.insert(batch.size(), r);
      endfunction

      // Narrow the keyword candidates by one identifier byte
      function void feed_word(logic [7:0] c);
         logic [5:0] nxt;
         logic [7:0] kc;
         nxt = '0;
         for (int k = 0; k < 6; k++) begin
            if (cand[k] && len < kw_word[k].len()) begin
               kc = kw_word[k][len];
               if (kc == c) nxt[k] = 1'b1;
            end
         end
         cand = nxt;
         if (len != 4'd15) len = len + 4'd1;
      endfunction

      function logic [4:0] word_kind();
         for (int k = 0; k < 6; k++) begin
            if (cand[k] && len == kw_word[k].len()) return kw_kind[k];
         end
         return bst_pkg::KIND_IDENT;
      endfunction

      // Close the open token; the marker rides on an open text byte if possible
      function void close_token();
         logic           has_kind;
         logic [4:0]     kd;
         int             n;
         tok_result_type t;
         has_kind = 1'b1;
         kd       = bst_pkg::KIND_EOF;
         case (mode)
            bst_pkg::MODE_STR:   kd = bst_pkg::KIND_STRING;
            bst_pkg::MODE_NUM:   kd = dot ? bst_pkg::KIND_FLOAT : bst_pkg::KIND_NUMBER;
            bst_pkg::MODE_IDENT: kd = word_kind();
            bst_pkg::MODE_GT: begin
               emit(1'b1, ">", 1'b1, bst_pkg::KIND_GT);
               has_kind = 1'b0;
            end
            bst_pkg::MODE_LT: begin
               emit(1'b1, "<", 1'b1, bst_pkg::KIND_LT);
               has_kind = 1'b0;
            end
            bst_pkg::MODE_EQ: begin
               emit(1'b1, "=", 1'b1, bst_pkg::KIND_ASSIGN);
               has_kind = 1'b0;
            end
            bst_pkg::MODE_SLASH: begin
               emit(1'b1, "/", 1'b1, bst_pkg::KIND_DIV);
               has_kind = 1'b0;
            end
            default: has_kind = 1'b0;
         endcase
         if (has_kind) begin
            n = batch.size();
            if (n > 0 && batch[n-1].byte_valid && !batch[n-1].token_done) begin
               t = batch[n-1];
               t.token_done = 1'b1;
               t.token_kind = kd;
               batch[n-1] = t;
            end else begin
               emit(1'b0, 8'h00, 1'b1, kd);
            end
         end
         go_idle();
      endfunction

      // Scan a byte with no token open
      function void begin_token(logic [7:0] c);
         go_idle();
         if (blank_char(c)) return;
         if (c == "\"") begin
            mode = bst_pkg::MODE_STR;
         end else if (digit_char(c)) begin
            mode = bst_pkg::MODE_NUM;
            emit(1'b1, c, 1'b0, bst_pkg::KIND_EOF);
         end else if (letter_char(c) || c == "_") begin
            mode = bst_pkg::MODE_IDENT;
            feed_word(c);
            emit(1'b1, c, 1'b0, bst_pkg::KIND_EOF);
         end else begin
            case (c)
               ">": mode = bst_pkg::MODE_GT;
               "<": mode = bst_pkg::MODE_LT;
               "=": mode = bst_pkg::MODE_EQ;
               "!": mode = bst_pkg::MODE_BANG;
               "/": mode = bst_pkg::MODE_SLASH;
               "+": emit(1'b1, c, 1'b1, bst_pkg::KIND_PLUS);
               "-": emit(1'b1, c, 1'b1, bst_pkg::KIND_MINUS);
               "*": emit(1'b1, c, 1'b1, bst_pkg::KIND_MUL);
               "(": emit(1'b1, c, 1'b1, bst_pkg::KIND_LPAREN);
               ")": emit(1'b1, c, 1'b1, bst_pkg::KIND_RPAREN);
               "{": emit(1'b1, c, 1'b1, bst_pkg::KIND_LBRACE);
               "}": emit(1'b1, c, 1'b1, bst_pkg::KIND_RBRACE);
               default: ;
            endcase
         end
      endfunction

      // Scan one valid nonzero byte in the current mode
      function void scan_char(logic [7:0] c);
         logic [7:0] first;
         logic [4:0] kd;
         case (mode)
            bst_pkg::MODE_STR: begin
               if (c == "\"") close_token();
               else emit(1'b1, c, 1'b0, bst_pkg::KIND_EOF);
            end
            bst_pkg::MODE_NUM: begin
               if (digit_char(c)) begin
                  emit(1'b1, c, 1'b0, bst_pkg::KIND_EOF);
               end else if (c == "." && !dot) begin
                  dot = 1'b1;
                  emit(1'b1, c, 1'b0, bst_pkg::KIND_EOF);
               end else if (c == ".") begin
                  close_token();
               end else begin
                  close_token();
                  begin_token(c);
               end
            end
            bst_pkg::MODE_IDENT: begin
               if (letter_char(c) || digit_char(c) || c == "_") begin
                  feed_word(c);
                  emit(1'b1, c, 1'b0, bst_pkg::KIND_EOF);
               end else begin
                  close_token();
                  begin_token(c);
               end
            end
            bst_pkg::MODE_COMMENT: begin
               if (c == 8'h0a) go_idle();
            end
            bst_pkg::MODE_GT, bst_pkg::MODE_LT, bst_pkg::MODE_EQ: begin
               if (c == "=") begin
                  first = (mode == bst_pkg::MODE_GT) ? 8'h3e :
                          ((mode == bst_pkg::MODE_LT) ? 8'h3c : 8'h3d);
                  kd    = (mode == bst_pkg::MODE_GT) ? bst_pkg::KIND_GE :
                          ((mode == bst_pkg::MODE_LT) ? bst_pkg::KIND_LE : bst_pkg::KIND_EQ);
                  emit(1'b1, first, 1'b0, bst_pkg::KIND_EOF);
                  emit(1'b1, "=", 1'b1, kd);
                  go_idle();
               end else begin
                  close_token();
                  begin_token(c);
               end
            end
            bst_pkg::MODE_BANG: begin
               if (c == "=") begin
                  emit(1'b1, "!", 1'b0, bst_pkg::KIND_EOF);
                  emit(1'b1, "=", 1'b1, bst_pkg::KIND_NE);
                  go_idle();
               end else begin
                  begin_token(c);
               end
            end
            bst_pkg::MODE_SLASH: begin
               if (c == "/") begin
                  mode = bst_pkg::MODE_COMMENT;
               end else begin
                  close_token();
                  begin_token(c);
               end
            end
            default: begin_token(c);
         endcase
      endfunction

      // Predict the results of one accepted source item and queue them
      function void note_source_item(src_item_type it);
         logic           fin;
         tok_result_type t;
         batch.delete();
         fin = it.end_of_text;
         if (it.has_char && it.ch == 8'h00) fin = 1'b1;
         else if (it.has_char) scan_char(it.ch);
         if (fin) begin
            close_token();
            emit(1'b0, 8'h00, 1'b1, bst_pkg::KIND_EOF);
            go_idle();
         end
         if (batch.size() > 0) begin
            t = batch[batch.size()-1];
            t.last = 1'b1;
            batch[batch.size()-1] = t;
         end
         foreach (batch[i]) expected_results.insert(expected_results.size(), batch[i]);
      endfunction

      // Compare one result against the oldest expectation
      function void check_token_result(tok_result_type got);
         tok_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result bv=%0b byte=%02h done=%0b kind=%0d last=%0b",
                     $realtime, got.byte_valid, got.text_byte, got.token_done,
                     got.token_kind, got.last);
            return;
         end
         want = expected_results.pop_front();
         if (got.byte_valid !== want.byte_valid || got.text_byte !== want.text_byte ||
             got.token_done !== want.token_done || got.token_kind !== want.token_kind ||
             got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected bv=%0b byte=%02h done=%0b kind=%0d last=%0b",
                     $realtime, want.byte_valid, want.text_byte, want.token_done,
                     want.token_kind, want.last);
            $display("%0t:          got      bv=%0b byte=%02h done=%0b kind=%0d last=%0b",
                     $realtime, got.byte_valid, got.text_byte, got.token_done,
                     got.token_kind, got.last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_byte
   logic        req_tuser = 1'b0;    // [0] has_char
   logic        req_tlast = 1'b0;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [0] byte_valid, [8:1] text_byte, [9] token_done
   logic [4:0]  rsp_tuser;           // [4:0] token_kind
   logic        rsp_tlast;

   token_tracker_type tracker;
   src_item_type      source_text[$];
   int                counted_items = 0;
   int                accepted_items = 0;
   bit                quiet_phase = 1'b0;
   bit                held_long = 1'b0;
   int                stall_left = 0;

   byte_stream_tokenizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Source text building
   function automatic void push_item(logic [7:0] c, logic hc, logic eot);
      source_text.insert(source_text.size(),
                         src_item_type'{ch: c, has_char: hc, end_of_text: eot});
      if (hc || eot) counted_items++;
   endfunction

   function automatic void push_char(logic [7:0] c);
      push_item(c, 1'b1, 1'b0);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   function automatic logic [7:0] pick_char(string pool);
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   // Append one mostly well-formed token with random content
   function automatic void add_random_token();
      string      words[6];
      string      ops[8];
      string      wordchars;
      string      w;
      logic [7:0] c;
      int         n;
      words     = '{"show", "wondering", "omae", "wa", "true", "false"};
      ops       = '{">", ">=", "<", "<=", "=", "==", "!=", "!"};
      wordchars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      case ($urandom_range(0, 10))
         0, 1: push_text(words[$urandom_range(0, 5)]);
         2: begin
            // keyword prefix or keyword with extra bytes
            w = words[$urandom_range(0, 5)];
            if ($urandom_range(0, 1)) w = w.substr(0, $urandom_range(0, w.len() - 2));
            else w = {w, "x"};
            push_text(w);
         end
         3: begin
            push_char(pick_char(wordchars.substr(0, 52)));
            n = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(0, 5);
            repeat (n) push_char(pick_char(wordchars));
         end
         4: begin
            repeat ($urandom_range(1, 4)) push_char(pick_char("0123456789"));
            if ($urandom_range(0, 1)) begin
               push_char(".");
               repeat ($urandom_range(0, 3)) push_char(pick_char("0123456789"));
               // a second dot closes the number
               if ($urandom_range(0, 2) == 0) push_char(".");
            end
         end
         5: begin
            push_char("\"");
            repeat ($urandom_range(0, 5)) begin
               c = 8'($urandom_range(1, 255));
               if (c == "\"") c = "s";
               push_char(c);
            end
            if ($urandom_range(0, 5) != 0) push_char("\"");
         end
         6, 7: push_text(ops[$urandom_range(0, 7)]);
         8: push_char(pick_char("+-*(){}/"));
         9: begin
            push_text("//");
            repeat ($urandom_range(0, 4)) begin
               c = 8'($urandom_range(1, 255));
               if (c == 8'h0a) c = "x";
               push_char(c);
            end
            push_char(8'h0a);
         end
         default: push_char(pick_char("+-*(){}"));
      endcase
      // separator, or none so that tokens abut
      if ($urandom_range(0, 1)) push_char(pick_char(" \t\n\r"));
   endfunction

   function automatic void build_source_text();
      int stop_at;
      // directed: identifiers, operators, lone bang, div, comment, open string
      push_text("a1<b>=c!=d!e/f//q\n\"z");
      push_item(8'h00, 1'b0, 1'b1);
      // float closed by a second dot, an unknown byte, assign flushed by a zero byte
      push_text("7.5.");
      push_char(8'hff);
      push_char("=");
      push_char(8'h00);
      push_item(8'haa, 1'b0, 1'b0);
      push_item(")", 1'b1, 1'b1);

      // random text, mostly well-formed
      stop_at = counted_items + 90;
      while (counted_items < stop_at) begin
         case ($urandom_range(0, 19))
            0: push_char(8'($urandom_range(1, 255)));
            1: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            2: begin
               case ($urandom_range(0, 2))
                  0: push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                  1: push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                  default: push_char(8'h00);
               endcase
            end
            default: add_random_token();
         endcase
      end
      push_item(8'h00, 1'b0, 1'b1);
   endfunction

   // Offer one item and hold it until accepted
   task automatic send_item(src_item_type it);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.ch;
      req_tuser  <= it.has_char;
      req_tlast  <= it.end_of_text;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_source_item(it);
      accepted_items++;
   endtask

   // Result side: random stall bursts and one long hold-off
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) rsp_tready <= 1'b1;
         end else if (!held_long && accepted_items >= 40) begin
            held_long  = 1'b1;
            stall_left = 80;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Check every result taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_token_result('{byte_valid: rsp_tdata[0], text_byte: rsp_tdata[8:1],
                                      token_done: rsp_tdata[9], token_kind: rsp_tuser,
                                      last: rsp_tlast});
   end

   initial begin
      tracker = new();
      build_source_text();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (source_text[i]) begin
         quiet_phase = (source_text.size() - i) <= 25;
         send_item(source_text[i]);
      end
      req_tvalid <= 1'b0;
      // drain, then allow for stray results
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
